// ===== sv/itoa_pkg.sv =====
// shared types and constants for the integer to ascii digit converter
package itoa_pkg;

  // widths of the conversion datapath
  localparam int unsigned ValueW  = 64;
  localparam int unsigned NumBcd  = 20;
  localparam int unsigned BcdW    = 4 * NumBcd;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StepW   = 6;

  // conversion modes
  localparam logic [2:0] CMD_SDEC32 = 3'd0;
  localparam logic [2:0] CMD_UDEC32 = 3'd1;
  localparam logic [2:0] CMD_HEX32L = 3'd2;
  localparam logic [2:0] CMD_HEX32U = 3'd3;
  localparam logic [2:0] CMD_UDEC64 = 3'd4;
  localparam logic [2:0] CMD_HEX64L = 3'd5;
  localparam logic [2:0] CMD_HEX64U = 3'd6;

  // input transaction
  typedef struct packed {
    logic [2:0]        cmd;
    logic [ValueW-1:0] value;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0]        character;
    logic              last;
    logic [CountW-1:0] char_count;
  } out_t;

  // operations of the digit unit
  typedef enum logic [2:0] {
    DOP_HOLD,
    DOP_LOAD_BIN,
    DOP_LOAD_HEX64,
    DOP_LOAD_HEX32,
    DOP_STEP,
    DOP_SHIFT
  } dig_op_e;

  // control from the sequencer to the digit unit
  typedef struct packed {
    dig_op_e           op;
    logic [ValueW-1:0] value;
  } dig_ctl_t;

endpackage

// ===== sv/itoa_bcd_step.sv =====
// one double-dabble step: add-3 correction on every bcd digit, then shift in one bit
module itoa_bcd_step (
  input  logic [itoa_pkg::BcdW-1:0] bcd_i,
  input  logic                      bit_i,
  output logic [itoa_pkg::BcdW-1:0] bcd_o
);

  logic [itoa_pkg::BcdW-1:0] adj;

  // correct each digit that would overflow past nine after doubling
  always_comb begin
    for (int i = 0; i < itoa_pkg::NumBcd; i++) begin
      if (bcd_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_i[4*i +: 4];
      end
    end
  end

  // double and bring in the next binary bit
  assign bcd_o = {adj[itoa_pkg::BcdW-2:0], bit_i};

endmodule

// ===== sv/itoa_digit_unit.sv =====
// digit register with binary shifter; forms decimal digits or loads hex digits and shifts them out top first
module itoa_digit_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itoa_pkg::dig_ctl_t   ctl_i,
  output logic [3:0]           top_digit_o
);

  logic [itoa_pkg::ValueW-1:0] bin_q, bin_d;
  logic [itoa_pkg::BcdW-1:0]   dig_q, dig_d;
  logic [itoa_pkg::BcdW-1:0]   step_bcd;

  // shared shift and add-3 unit
  itoa_bcd_step u_step (
    .bcd_i (dig_q),
    .bit_i (bin_q[itoa_pkg::ValueW-1]),
    .bcd_o (step_bcd)
  );

  // next value of the binary and digit registers
  always_comb begin
    bin_d = bin_q;
    dig_d = dig_q;
    case (ctl_i.op)
      itoa_pkg::DOP_HOLD: begin
      end
      itoa_pkg::DOP_LOAD_BIN: begin
        bin_d = ctl_i.value;
        dig_d = '0;
      end
      itoa_pkg::DOP_LOAD_HEX64: begin
        dig_d = {ctl_i.value, {(itoa_pkg::BcdW - itoa_pkg::ValueW){1'b0}}};
      end
      itoa_pkg::DOP_LOAD_HEX32: begin
        dig_d = {ctl_i.value[31:0], {(itoa_pkg::BcdW - 32){1'b0}}};
      end
      itoa_pkg::DOP_STEP: begin
        bin_d = {bin_q[itoa_pkg::ValueW-2:0], 1'b0};
        dig_d = step_bcd;
      end
      itoa_pkg::DOP_SHIFT: begin
        dig_d = {dig_q[itoa_pkg::BcdW-5:0], 4'h0};
      end
      default: begin
      end
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      dig_q <= '0;
    end else begin
      bin_q <= bin_d;
      dig_q <= dig_d;
    end
  end

  assign top_digit_o = dig_q[itoa_pkg::BcdW-1 -: 4];

endmodule

// ===== sv/integer_to_ascii_digits.sv =====
// top level of the integer to ascii digit converter
// Converts one integer per input transaction into a stream of ASCII characters, most
// significant first, one character per output transaction; the final one has last set and
// carries the character count. Decimal modes run a double-dabble conversion on the shared
// shift and add-3 unit over all 64 bits, whatever the mode width; hex modes skip it. Leading
// zero digits are then dropped at one per cycle (up to 19 for decimal, 15 or 7 for hex),
// the count is then settled, and each character passes through the output register. The
// input stays stalled from acceptance until the last character has been handed to the
// output register, also while the output stalls, so a new item is taken only after the
// last one is through. Mode 7 is taken and produces nothing.
module integer_to_ascii_digits (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  itoa_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output itoa_pkg::out_t  out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                      state_q;
  logic [itoa_pkg::StepW-1:0]  step_q;
  logic [itoa_pkg::CountW-1:0] rem_q;
  logic [itoa_pkg::CountW-1:0] total_q;
  logic                        neg_q;
  logic                        upper_q;
  logic                        out_valid_q;
  itoa_pkg::out_t              out_q;

  itoa_pkg::dig_ctl_t          dig_ctl;
  logic [3:0]                  top_digit;
  logic                        in_fire;
  logic                        slot_free;
  logic                        out_load;
  logic                        is_neg;
  logic [31:0]                 mag32;
  logic                        skip_more;

  // ascii code of one digit
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else if (upper) begin
      c = 8'h41 + {4'h0, d - 4'd10};
    end else begin
      c = 8'h61 + {4'h0, d - 4'd10};
    end
    return c;
  endfunction

  itoa_digit_unit u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (dig_ctl),
    .top_digit_o (top_digit)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_load    = slot_free && ((state_q == ST_SIGN) || (state_q == ST_EMIT));
  assign is_neg      = (in_data_i.cmd == itoa_pkg::CMD_SDEC32) && in_data_i.value[31];
  assign mag32       = is_neg ? (32'd0 - in_data_i.value[31:0]) : in_data_i.value[31:0];
  assign skip_more   = (top_digit == 4'h0) && (rem_q > itoa_pkg::CountW'(1));

  // control of the digit unit
  always_comb begin
    dig_ctl.op    = itoa_pkg::DOP_HOLD;
    dig_ctl.value = in_data_i.value;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.cmd)
            itoa_pkg::CMD_SDEC32, itoa_pkg::CMD_UDEC32: begin
              dig_ctl.op    = itoa_pkg::DOP_LOAD_BIN;
              dig_ctl.value = {32'h0, mag32};
            end
            itoa_pkg::CMD_UDEC64: dig_ctl.op = itoa_pkg::DOP_LOAD_BIN;
            itoa_pkg::CMD_HEX32L, itoa_pkg::CMD_HEX32U: dig_ctl.op = itoa_pkg::DOP_LOAD_HEX32;
            itoa_pkg::CMD_HEX64L, itoa_pkg::CMD_HEX64U: dig_ctl.op = itoa_pkg::DOP_LOAD_HEX64;
            default: dig_ctl.op = itoa_pkg::DOP_HOLD;
          endcase
        end
      end
      ST_CONV: dig_ctl.op = itoa_pkg::DOP_STEP;
      ST_SKIP: begin
        if (skip_more) begin
          dig_ctl.op = itoa_pkg::DOP_SHIFT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          dig_ctl.op = itoa_pkg::DOP_SHIFT;
        end
      end
      default: dig_ctl.op = itoa_pkg::DOP_HOLD;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rem_q       <= '0;
      total_q     <= '0;
      neg_q       <= 1'b0;
      upper_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // output slot fills with a new character and empties when taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            neg_q   <= is_neg;
            upper_q <= (in_data_i.cmd == itoa_pkg::CMD_HEX32U) ||
                       (in_data_i.cmd == itoa_pkg::CMD_HEX64U);
            step_q  <= itoa_pkg::StepW'(itoa_pkg::ValueW - 1);
            case (in_data_i.cmd)
              itoa_pkg::CMD_SDEC32, itoa_pkg::CMD_UDEC32, itoa_pkg::CMD_UDEC64: begin
                state_q <= ST_CONV;
              end
              itoa_pkg::CMD_HEX32L, itoa_pkg::CMD_HEX32U: begin
                rem_q   <= itoa_pkg::CountW'(8);
                state_q <= ST_SKIP;
              end
              itoa_pkg::CMD_HEX64L, itoa_pkg::CMD_HEX64U: begin
                rem_q   <= itoa_pkg::CountW'(16);
                state_q <= ST_SKIP;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_CONV: begin
          step_q <= step_q - itoa_pkg::StepW'(1);
          if (step_q == '0) begin
            rem_q   <= itoa_pkg::CountW'(itoa_pkg::NumBcd);
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_more) begin
            rem_q <= rem_q - itoa_pkg::CountW'(1);
          end else begin
            total_q <= rem_q + itoa_pkg::CountW'(neg_q);
            state_q <= neg_q ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_q.character  <= 8'h2d;
            out_q.last       <= 1'b0;
            out_q.char_count <= '0;
            state_q          <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_q.character  <= digit_char(top_digit, upper_q);
            out_q.last       <= (rem_q == itoa_pkg::CountW'(1));
            out_q.char_count <= (rem_q == itoa_pkg::CountW'(1)) ? total_q : '0;
            rem_q            <= rem_q - itoa_pkg::CountW'(1);
            if (rem_q == itoa_pkg::CountW'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a pending character is never dropped while the consumer stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("pending output lost under stall");

  // last character carries a nonzero count, others carry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last ? (out_q.char_count != '0) : (out_q.char_count == '0)))
    else $error("char_count inconsistent with last");

  // emission never runs with no digits left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) || (state_q == ST_SKIP) || (state_q == ST_SIGN) |-> rem_q != '0)
    else $error("digit count underflow");

  // the sign goes out only for a negative signed number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |-> neg_q)
    else $error("sign emitted for a non-negative number");

endmodule
